[src/tvk_pkg.sv]
package tvk_pkg;

    localparam int FINGER_SLOTS = 10;
    localparam int ID_BITS      = 32;
    localparam int KEY_BITS     = 9;

    // key mask bit positions
    localparam int KEY_UP     = 0;
    localparam int KEY_DOWN   = 1;
    localparam int KEY_LEFT   = 2;
    localparam int KEY_RIGHT  = 3;
    localparam int KEY_A      = 4;
    localparam int KEY_B      = 5;
    localparam int KEY_SELECT = 6;
    localparam int KEY_START  = 7;
    localparam int KEY_MENU   = 8;

    typedef enum logic [1:0] {
        SLOT_CLAIM   = 2'd0,
        SLOT_UPDATE  = 2'd1,
        SLOT_RELEASE = 2'd2
    } slot_op_t;

    typedef struct packed {
        logic                apply;
        slot_op_t            kind;
        logic [ID_BITS-1:0]  id;
        logic [KEY_BITS-1:0] keys;
    } slot_cmd_t;

endpackage

[src/tvk_cell.sv]
module tvk_cell
    import tvk_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  slot_cmd_t           cmd,
    input  logic                free_in,    // an earlier slot is free
    input  logic                match_in,   // an earlier slot holds this finger
    input  logic [KEY_BITS-1:0] union_in,
    output logic                free_out,
    output logic                match_out,
    output logic [KEY_BITS-1:0] union_out
);

    logic                down_reg;
    logic                down_next;
    logic [KEY_BITS-1:0] keys_reg;
    logic [KEY_BITS-1:0] keys_next;
    logic [ID_BITS-1:0]  id_reg;
    logic                free_here;
    logic                match_here;
    logic                take_claim;
    logic                take_match;

    assign free_here  = !down_reg;
    assign match_here = down_reg && (id_reg == cmd.id);
    assign free_out   = free_in | free_here;
    assign match_out  = match_in | match_here;
    assign union_out  = union_in | (down_reg ? keys_reg : '0);

    assign take_claim = cmd.apply && free_here && !free_in;
    assign take_match = cmd.apply && match_here && !match_in;

    always_comb
    begin
        down_next = down_reg;
        keys_next = keys_reg;
        unique case (cmd.kind)
            SLOT_CLAIM:
            begin
                if (take_claim)
                begin
                    down_next = 1'b1;
                    keys_next = cmd.keys;
                end
            end
            SLOT_UPDATE:
            begin
                if (take_match)
                begin
                    keys_next = cmd.keys;
                end
            end
            SLOT_RELEASE:
            begin
                if (take_match)
                begin
                    down_next = 1'b0;
                    keys_next = '0;
                end
            end
            default:
            begin
                down_next = down_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            down_reg <= 1'b0;
            keys_reg <= '0;
        end
        else
        begin
            down_reg <= down_next;
            keys_reg <= keys_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.kind == SLOT_CLAIM && take_claim)
        begin
            id_reg <= cmd.id;
        end
    end

endmodule

[src/tvk_hit.sv]
module tvk_hit
    import tvk_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [15:0]         pos_x,
    input  logic [15:0]         pos_y,
    input  logic [11:0]         width,
    input  logic [11:0]         height,
    input  logic [15:0]         scale,
    output logic                done,
    output logic [KEY_BITS-1:0] keys
);

    typedef enum logic [2:0] {
        H_IDLE = 3'b001,
        H_PREP = 3'b010,
        H_RUN  = 3'b100
    } hit_state_t;

    localparam logic [2:0] R_PAD   = 3'd0;
    localparam logic [2:0] R_A     = 3'd1;
    localparam logic [2:0] R_B     = 3'd2;
    localparam logic [2:0] R_MENU  = 3'd3;
    localparam logic [2:0] R_SEL   = 3'd4;
    localparam logic [2:0] R_START = 3'd5;

    localparam logic [23:0] SCALE_MIN = 24'd39322;
    localparam logic [27:0] RECIP15   = 28'd143165577;   // ceil(2^31/15)
    localparam logic [14:0] TAN22     = 15'd27146;

    function automatic logic [30:0] scaled(input logic [23:0] s, input logic [6:0] k);
        logic [30:0] sw;
        sw = 31'(s);
        return sw * 31'(k);
    endfunction

    hit_state_t          state_reg;
    logic [1:0]          step_reg;
    logic [2:0]          region_reg;
    logic [2:0]          phase_reg;
    logic                done_reg;
    logic [KEY_BITS-1:0] keys_reg;

    logic [15:0]         x_reg;
    logic [15:0]         y_reg;
    logic [27:0]         n_reg;
    logic [23:0]         s_reg;
    logic [27:0]         px_reg;
    logic [27:0]         py_reg;
    logic signed [33:0]  cx_reg;
    logic signed [33:0]  cy_reg;
    logic [32:0]         rad_reg;
    logic [32:0]         inr_reg;
    logic [32:0]         ax_reg;
    logic [32:0]         ay_reg;
    logic                dxn_reg;
    logic                dxp_reg;
    logic                dyn_reg;
    logic                dyp_reg;
    logic [47:0]         tanx_reg;
    logic [47:0]         tany_reg;
    logic [49:0]         sq_lo_reg;
    logic [48:0]         sq_hi_reg;
    logic [65:0]         sq_reg;
    logic [66:0]         d2_reg;
    logic                outer_reg;

    logic [54:0]         recip_prod;
    logic signed [33:0]  wq;
    logic signed [33:0]  hq;
    logic [27:0]         sel_x;
    logic [27:0]         start_x;
    logic [27:0]         sel_frac;
    logic [27:0]         start_frac;
    logic signed [33:0]  cx_c;
    logic signed [33:0]  cy_c;
    logic [32:0]         rad_c;
    logic [32:0]         inr_c;
    logic signed [33:0]  dx_c;
    logic signed [33:0]  dy_c;
    logic [33:0]         adx_c;
    logic [33:0]         ady_c;
    logic [32:0]         sq_op;
    logic [2:0]          last_phase;
    logic [48:0]         ay_sh;
    logic [48:0]         ax_sh;

    assign done = done_reg;
    assign keys = keys_reg;

    assign recip_prod = 55'(n_reg[27:1]) * 55'(RECIP15);
    assign wq = $signed({6'd0, width, 16'd0});
    assign hq = $signed({6'd0, height, 16'd0});

    // x centers of select and start: W*0.4 and W*0.6 in Q16, floored
    assign sel_frac   = 28'({width, 1'b0}) * 28'(13108);
    assign start_frac = (28'(width) * 28'(3)) * 28'(13108);
    assign sel_x      = 28'(width) * 28'(26214) + (sel_frac >> 16);
    assign start_x    = 28'(width) * 28'(39321) + (start_frac >> 16);

    always_comb
    begin
        cx_c  = '0;
        cy_c  = '0;
        rad_c = '0;
        inr_c = '0;
        unique case (region_reg)
            R_PAD:
            begin
                cx_c  = $signed({3'd0, scaled(s_reg, 7'd90)});
                cy_c  = hq - $signed({3'd0, scaled(s_reg, 7'd90)});
                rad_c = {2'd0, scaled(s_reg, 7'd80)};
                inr_c = {2'd0, scaled(s_reg, 7'd16)};
            end
            R_A:
            begin
                cx_c  = wq - $signed({3'd0, scaled(s_reg, 7'd55)});
                cy_c  = hq - $signed({3'd0, scaled(s_reg, 7'd105)});
                rad_c = {2'd0, scaled(s_reg, 7'd38)};
            end
            R_B:
            begin
                cx_c  = wq - $signed({3'd0, scaled(s_reg, 7'd125)});
                cy_c  = hq - $signed({3'd0, scaled(s_reg, 7'd55)});
                rad_c = {2'd0, scaled(s_reg, 7'd38)};
            end
            R_MENU:
            begin
                cx_c  = wq - $signed({3'd0, scaled(s_reg, 7'd40)});
                cy_c  = $signed({3'd0, scaled(s_reg, 7'd35)});
                rad_c = {2'd0, scaled(s_reg, 7'd30)};
            end
            R_SEL:
            begin
                cx_c  = $signed({6'd0, sel_x});
                cy_c  = hq - $signed({3'd0, scaled(s_reg, 7'd30)});
                rad_c = {2'd0, scaled(s_reg, 7'd35)};
                inr_c = {2'd0, scaled(s_reg, 7'd20)};
            end
            R_START:
            begin
                cx_c  = $signed({6'd0, start_x});
                cy_c  = hq - $signed({3'd0, scaled(s_reg, 7'd30)});
                rad_c = {2'd0, scaled(s_reg, 7'd35)};
                inr_c = {2'd0, scaled(s_reg, 7'd20)};
            end
            default:
            begin
                cx_c = '0;
            end
        endcase
    end

    assign dx_c  = $signed({6'd0, px_reg}) - cx_reg;
    assign dy_c  = $signed({6'd0, py_reg}) - cy_reg;
    assign adx_c = dx_c[33] ? 34'(-dx_c) : 34'(dx_c);
    assign ady_c = dy_c[33] ? 34'(-dy_c) : 34'(dy_c);
    assign ay_sh = {ay_reg, 16'd0};
    assign ax_sh = {ax_reg, 16'd0};

    always_comb
    begin
        unique case (phase_reg)
            3'd3:    sq_op = ay_reg;
            3'd4:    sq_op = rad_reg;
            3'd5:    sq_op = inr_reg;
            default: sq_op = ax_reg;
        endcase
    end

    always_comb
    begin
        priority if (region_reg == R_PAD)
        begin
            last_phase = 3'd7;
        end
        else if (region_reg == R_SEL || region_reg == R_START)
        begin
            last_phase = 3'd2;
        end
        else
        begin
            last_phase = 3'd6;
        end
    end

    // two-stage squarer: operand split into a 17-bit low part and a 16-bit high part
    always_ff @(posedge clk)
    begin
        sq_lo_reg <= 50'(sq_op) * 50'(sq_op[16:0]);
        sq_hi_reg <= 49'(sq_op) * 49'(sq_op[32:17]);
        sq_reg    <= 66'(sq_lo_reg) + {sq_hi_reg, 17'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= H_IDLE;
            step_reg   <= '0;
            region_reg <= R_PAD;
            phase_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                H_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= H_PREP;
                        step_reg  <= '0;
                    end
                end
                H_PREP:
                begin
                    step_reg <= step_reg + 2'd1;
                    if (step_reg == 2'd2)
                    begin
                        state_reg  <= H_RUN;
                        region_reg <= R_PAD;
                        phase_reg  <= '0;
                    end
                end
                H_RUN:
                begin
                    if (phase_reg == last_phase)
                    begin
                        phase_reg <= '0;
                        if (region_reg == R_START)
                        begin
                            state_reg <= H_IDLE;
                            done_reg  <= 1'b1;
                        end
                        else
                        begin
                            region_reg <= region_reg + 3'd1;
                        end
                    end
                    else
                    begin
                        phase_reg <= phase_reg + 3'd1;
                    end
                end
                default:
                begin
                    state_reg <= H_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == H_IDLE && start)
        begin
            x_reg    <= pos_x;
            y_reg    <= pos_y;
            keys_reg <= '0;
        end
        if (state_reg == H_PREP)
        begin
            unique case (step_reg)
                2'd0: n_reg <= 28'(height) * 28'(scale);
                2'd1: s_reg <= recip_prod[54:31];
                default:
                begin
                    if (s_reg < SCALE_MIN)
                    begin
                        s_reg <= SCALE_MIN;
                    end
                    px_reg <= 28'(x_reg) * 28'(width);
                    py_reg <= 28'(y_reg) * 28'(height);
                end
            endcase
        end
        if (state_reg == H_RUN)
        begin
            unique case (phase_reg)
                3'd0:
                begin
                    cx_reg  <= cx_c;
                    cy_reg  <= cy_c;
                    rad_reg <= rad_c;
                    inr_reg <= inr_c;
                end
                3'd1:
                begin
                    ax_reg  <= adx_c[32:0];
                    ay_reg  <= ady_c[32:0];
                    dxn_reg <= dx_c[33];
                    dyn_reg <= dy_c[33];
                    dxp_reg <= !dx_c[33] && (dx_c != '0);
                    dyp_reg <= !dy_c[33] && (dy_c != '0);
                end
                3'd2:
                begin
                    tanx_reg <= 48'(ax_reg) * 48'(TAN22);
                    tany_reg <= 48'(ay_reg) * 48'(TAN22);
                    if (ax_reg < rad_reg && ay_reg < inr_reg)
                    begin
                        if (region_reg == R_SEL)
                        begin
                            keys_reg[KEY_SELECT] <= 1'b1;
                        end
                        if (region_reg == R_START)
                        begin
                            keys_reg[KEY_START] <= 1'b1;
                        end
                    end
                end
                3'd4:
                begin
                    d2_reg <= 67'(sq_reg);
                end
                3'd5:
                begin
                    d2_reg <= d2_reg + 67'(sq_reg);
                end
                3'd6:
                begin
                    outer_reg <= d2_reg <= 67'(sq_reg);
                    if (d2_reg <= 67'(sq_reg))
                    begin
                        if (region_reg == R_A)
                        begin
                            keys_reg[KEY_A] <= 1'b1;
                        end
                        if (region_reg == R_B)
                        begin
                            keys_reg[KEY_B] <= 1'b1;
                        end
                        if (region_reg == R_MENU)
                        begin
                            keys_reg[KEY_MENU] <= 1'b1;
                        end
                    end
                end
                3'd7:
                begin
                    // ring between dead zone and outer edge, 45-degree sectors
                    if (outer_reg && d2_reg >= 67'(sq_reg))
                    begin
                        if (dyn_reg && ay_sh >= 49'(tanx_reg))
                        begin
                            keys_reg[KEY_UP] <= 1'b1;
                        end
                        if (dyp_reg && ay_sh >= 49'(tanx_reg))
                        begin
                            keys_reg[KEY_DOWN] <= 1'b1;
                        end
                        if (dxn_reg && 49'(tany_reg) <= ax_sh)
                        begin
                            keys_reg[KEY_LEFT] <= 1'b1;
                        end
                        if (dxp_reg && 49'(tany_reg) <= ax_sh)
                        begin
                            keys_reg[KEY_RIGHT] <= 1'b1;
                        end
                    end
                end
                default:
                begin
                    outer_reg <= outer_reg;
                end
            endcase
        end
    end

endmodule

[src/touch_virtual_keypad_mapper.sv]
// Touch keypad mapper. Each input beat is one touch event (op in tuser); each event gives
// exactly one output beat with the key union, the active-low pad and button nibbles, the
// menu latch and the controller-active flag. Finger down and move with mapping enabled run
// the hit test, a sequencer that walks six key regions through one shared two-stage
// squarer, then update the slots; other events skip the hit test. One event is in work
// at a time; a finished result waits in the output register while the next event is taken.
// Finger slots form a row of cells linked by priority and union chains. The user must see
// that configuration is written only while no event is in work; the block does not check.
module touch_virtual_keypad_mapper
    import tvk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // finger_id[31:0], pos_x[47:32], pos_y[63:48]
    input  logic [2:0]  s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // pressed_keys, pad_lines, button_lines, menu_pending,
                                   // pad_active, zero fill
);

    typedef enum logic [3:0] {
        T_IDLE   = 4'b0001,
        T_HIT    = 4'b0010,
        T_APPLY  = 4'b0100,
        T_RESULT = 4'b1000
    } top_state_t;

    localparam logic [2:0] OP_DOWN  = 3'd0;
    localparam logic [2:0] OP_MOVE  = 3'd1;
    localparam logic [2:0] OP_UP    = 3'd2;
    localparam logic [2:0] OP_PAD   = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;

    localparam logic [2:0] REG_ENABLE = 3'd0;
    localparam logic [2:0] REG_HIDE   = 3'd1;
    localparam logic [2:0] REG_WIDTH  = 3'd2;
    localparam logic [2:0] REG_HEIGHT = 3'd3;
    localparam logic [2:0] REG_SCALE  = 3'd4;

    logic        en_reg;
    logic        hide_reg;
    logic [11:0] width_reg;
    logic [11:0] height_reg;
    logic [15:0] scale_reg;

    top_state_t          state_reg;
    logic [2:0]          op_reg;
    logic [ID_BITS-1:0]  id_reg;
    logic [KEY_BITS-1:0] keys_reg;
    logic                pad_flag_reg;
    logic                menu_reg;
    logic                out_valid_reg;
    logic [23:0]         out_data_reg;

    logic                in_fire;
    logic                finger_op;
    logic                hit_start;
    logic                hit_done;
    logic [KEY_BITS-1:0] hit_keys;
    logic                out_load;
    logic                show;
    logic [3:0]          pad_lines;
    logic [3:0]          button_lines;
    slot_cmd_t           cmd;

    logic                free_chain  [FINGER_SLOTS+1];
    logic                match_chain [FINGER_SLOTS+1];
    logic [KEY_BITS-1:0] union_chain [FINGER_SLOTS+1];

    assign s_tready = (state_reg == T_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign finger_op = (s_tuser == OP_DOWN) || (s_tuser == OP_MOVE) || (s_tuser == OP_UP);
    assign hit_start = in_fire && en_reg && ((s_tuser == OP_DOWN) || (s_tuser == OP_MOVE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg     <= 1'b0;
            hide_reg   <= 1'b1;
            width_reg  <= 12'd640;
            height_reg <= 12'd480;
            scale_reg  <= 16'd4096;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_ENABLE: en_reg     <= cfg_data[0];
                REG_HIDE:   hide_reg   <= cfg_data[0];
                REG_WIDTH:  width_reg  <= cfg_data[11:0];
                REG_HEIGHT: height_reg <= cfg_data[11:0];
                REG_SCALE:  scale_reg  <= cfg_data;
                default:    en_reg     <= en_reg;
            endcase
        end
    end

    tvk_hit u_hit (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (hit_start),
        .pos_x  (s_tdata[47:32]),
        .pos_y  (s_tdata[63:48]),
        .width  (width_reg),
        .height (height_reg),
        .scale  (scale_reg),
        .done   (hit_done),
        .keys   (hit_keys)
    );

    always_comb
    begin
        cmd.apply = (state_reg == T_APPLY);
        cmd.id    = id_reg;
        cmd.keys  = keys_reg;
        unique case (op_reg)
            OP_DOWN: cmd.kind = SLOT_CLAIM;
            OP_MOVE: cmd.kind = SLOT_UPDATE;
            default: cmd.kind = SLOT_RELEASE;
        endcase
    end

    assign free_chain[0]  = 1'b0;
    assign match_chain[0] = 1'b0;
    assign union_chain[0] = '0;

    for (genvar i = 0; i < FINGER_SLOTS; i++)
    begin : g_slot
        tvk_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .free_in   (free_chain[i]),
            .match_in  (match_chain[i]),
            .union_in  (union_chain[i]),
            .free_out  (free_chain[i+1]),
            .match_out (match_chain[i+1]),
            .union_out (union_chain[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= T_IDLE;
            pad_flag_reg <= 1'b0;
            menu_reg     <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                T_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (finger_op)
                        begin
                            pad_flag_reg <= 1'b0;
                        end
                        if (s_tuser == OP_PAD)
                        begin
                            pad_flag_reg <= 1'b1;
                        end
                        if (s_tuser == OP_CLEAR)
                        begin
                            menu_reg <= 1'b0;
                        end
                        priority if (hit_start)
                        begin
                            state_reg <= T_HIT;
                        end
                        else if (en_reg && s_tuser == OP_UP)
                        begin
                            state_reg <= T_APPLY;
                        end
                        else
                        begin
                            state_reg <= T_RESULT;
                        end
                    end
                end
                T_HIT:
                begin
                    if (hit_done)
                    begin
                        state_reg <= T_APPLY;
                    end
                end
                T_APPLY:
                begin
                    // a down that found a free slot and landed on the menu key
                    if (op_reg == OP_DOWN && free_chain[FINGER_SLOTS] && keys_reg[KEY_MENU])
                    begin
                        menu_reg <= 1'b1;
                    end
                    state_reg <= T_RESULT;
                end
                T_RESULT:
                begin
                    if (out_load)
                    begin
                        state_reg <= T_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg   <= s_tuser;
            id_reg   <= ID_BITS'(s_tdata[31:0]);
            keys_reg <= '0;
        end
        else if (state_reg == T_HIT && hit_done)
        begin
            keys_reg <= hit_keys;
        end
    end

    assign out_load = (state_reg == T_RESULT) && (!out_valid_reg || m_tready);
    assign show     = en_reg && !(hide_reg && pad_flag_reg);
    assign pad_lines = show ? ~{union_chain[FINGER_SLOTS][KEY_DOWN],
                                union_chain[FINGER_SLOTS][KEY_UP],
                                union_chain[FINGER_SLOTS][KEY_LEFT],
                                union_chain[FINGER_SLOTS][KEY_RIGHT]} : 4'hF;
    assign button_lines = show ? ~union_chain[FINGER_SLOTS][KEY_START:KEY_A] : 4'hF;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= {5'd0, pad_flag_reg, menu_reg, button_lines, pad_lines,
                             union_chain[FINGER_SLOTS]};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_done_in_hit: assert property (@(posedge clk) disable iff (!rst_n)
        hit_done |-> state_reg == T_HIT)
        else $error("hit test finished outside of hit wait");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_tvalid)
        else $error("loaded result not presented");

    a_menu_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(menu_reg) |-> $past(state_reg == T_APPLY))
        else $error("menu latch set outside slot update");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_HIT) |-> !s_tready)
        else $error("input taken during hit test");

endmodule

[sim/touch_virtual_keypad_mapper_test.sv]
module touch_virtual_keypad_mapper_test;
    import tvk_pkg::*;

    localparam logic [2:0] OP_DOWN  = 3'd0;
    localparam logic [2:0] OP_MOVE  = 3'd1;
    localparam logic [2:0] OP_UP    = 3'd2;
    localparam logic [2:0] OP_PAD   = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;
    localparam logic [2:0] OP_RSV5  = 3'd5;
    localparam logic [2:0] OP_RSV7  = 3'd7;

    localparam logic [2:0] REG_ENABLE = 3'd0;
    localparam logic [2:0] REG_HIDE   = 3'd1;
    localparam logic [2:0] REG_WIDTH  = 3'd2;
    localparam logic [2:0] REG_HEIGHT = 3'd3;
    localparam logic [2:0] REG_SCALE  = 3'd4;

    localparam longint SCALE_FLOOR = 39322;
    localparam longint TAN_22      = 27146;
    localparam int     DRAIN       = 60;

    typedef struct packed {
        logic [8:0] keys;
        logic [3:0] pad;
        logic [3:0] btn;
        logic       menu;
        logic       active;
    } keypad_state_t;

    class keypad_scoreboard;
        bit            enable;
        bit            hide;
        longint        width;
        longint        height;
        longint        uscale;
        logic [31:0]   ids [FINGER_SLOTS];
        bit            down [FINGER_SLOTS];
        logic [8:0]    keys [FINGER_SLOTS];
        logic [8:0]    key_union;
        bit            menu_latch;
        bit            pad_flag;
        keypad_state_t expected_beats [$];
        int            mismatches;

        function new();
            enable = 0;
            hide = 1;
            width = 640;
            height = 480;
            uscale = 4096;
            key_union = '0;
            menu_latch = 0;
            pad_flag = 0;
            mismatches = 0;
            for (int i = 0; i < FINGER_SLOTS; i++)
            begin
                ids[i] = '0;
                down[i] = 0;
                keys[i] = '0;
            end
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] val);
            case (idx)
                REG_ENABLE: enable = val[0];
                REG_HIDE:   hide = val[0];
                REG_WIDTH:  width = val[11:0];
                REG_HEIGHT: height = val[11:0];
                REG_SCALE:  uscale = val;
                default: ;
            endcase
        endfunction

        function longint scale();
            longint s;
            s = (height * uscale) / 30;
            if (s < SCALE_FLOOR)
                s = SCALE_FLOOR;
            return s;
        endfunction

        function bit in_round(longint px, longint py, longint cx, longint cy, longint r);
            return (px - cx) * (px - cx) + (py - cy) * (py - cy) <= r * r;
        endfunction

        function bit in_rect(longint px, longint py, longint cx, longint cy,
                             longint hw, longint hh);
            longint ax, ay;
            ax = px - cx;
            ay = py - cy;
            if (ax < 0) ax = -ax;
            if (ay < 0) ay = -ay;
            return ax < hw && ay < hh;
        endfunction

        function logic [8:0] hit_keys(logic [15:0] x, logic [15:0] y);
            longint s, px, py, wq, hq, dx, dy, d2, ax, ay;
            logic [8:0] m;
            s = scale();
            px = longint'(x) * width;
            py = longint'(y) * height;
            wq = width * 65536;
            hq = height * 65536;
            m = '0;
            dx = px - 90 * s;
            dy = py - (hq - 90 * s);
            d2 = dx * dx + dy * dy;
            if (d2 <= (80 * s) * (80 * s) && d2 >= (16 * s) * (16 * s))
            begin
                ax = dx < 0 ? -dx : dx;
                ay = dy < 0 ? -dy : dy;
                if (dy < 0 && ay * 65536 >= ax * TAN_22) m[KEY_UP] = 1;
                if (dy > 0 && ay * 65536 >= ax * TAN_22) m[KEY_DOWN] = 1;
                if (dx < 0 && ay * TAN_22 <= ax * 65536) m[KEY_LEFT] = 1;
                if (dx > 0 && ay * TAN_22 <= ax * 65536) m[KEY_RIGHT] = 1;
            end
            m[KEY_A] = in_round(px, py, wq - 55 * s, hq - 105 * s, 38 * s);
            m[KEY_B] = in_round(px, py, wq - 125 * s, hq - 55 * s, 38 * s);
            m[KEY_SELECT] = in_rect(px, py, (width * 131072) / 5, hq - 30 * s, 35 * s, 20 * s);
            m[KEY_START] = in_rect(px, py, (width * 196608) / 5, hq - 30 * s, 35 * s, 20 * s);
            m[KEY_MENU] = in_round(px, py, wq - 40 * s, 35 * s, 30 * s);
            return m;
        endfunction

        function void note_event(logic [2:0] op, logic [31:0] id,
                                 logic [15:0] x, logic [15:0] y);
            keypad_state_t e;
            int hit;
            if (op <= OP_UP)
                pad_flag = 0;
            else if (op == OP_PAD)
                pad_flag = 1;
            else if (op == OP_CLEAR)
                menu_latch = 0;
            if (enable && op <= OP_UP)
            begin
                hit = -1;
                for (int i = 0; i < FINGER_SLOTS; i++)
                    if (hit < 0 && (op == OP_DOWN ? !down[i] : (down[i] && ids[i] == id)))
                        hit = i;
                if (hit >= 0)
                begin
                    if (op == OP_DOWN)
                    begin
                        ids[hit] = id;
                        down[hit] = 1;
                        keys[hit] = hit_keys(x, y);
                        if (keys[hit][KEY_MENU])
                            menu_latch = 1;
                    end
                    else if (op == OP_MOVE)
                        keys[hit] = hit_keys(x, y);
                    else
                    begin
                        down[hit] = 0;
                        keys[hit] = '0;
                    end
                end
                key_union = '0;
                for (int i = 0; i < FINGER_SLOTS; i++)
                    if (down[i])
                        key_union |= keys[i];
            end
            e.keys = key_union;
            e.pad = 4'hF;
            e.btn = 4'hF;
            if (enable && !(hide && pad_flag))
            begin
                e.pad = ~{key_union[KEY_DOWN], key_union[KEY_UP],
                          key_union[KEY_LEFT], key_union[KEY_RIGHT]};
                e.btn = ~{key_union[KEY_START], key_union[KEY_SELECT],
                          key_union[KEY_B], key_union[KEY_A]};
            end
            e.menu = menu_latch;
            e.active = pad_flag;
            expected_beats.push_back(e);
        endfunction

        function void check_beat(logic [23:0] data);
            keypad_state_t e, a;
            a.keys = data[8:0];
            a.pad = data[12:9];
            a.btn = data[16:13];
            a.menu = data[17];
            a.active = data[18];
            if (expected_beats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output beat %h", data);
                return;
            end
            e = expected_beats.pop_front();
            if (e != a || data[23:19] != 5'd0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: keys %h/%h pad %h/%h btn %h/%h menu %b/%b act %b/%b (exp/act)",
                             e.keys, a.keys, e.pad, a.pad, e.btn, a.btn,
                             e.menu, a.menu, e.active, a.active);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_wen;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    keypad_scoreboard sb;
    bit calm;
    bit hold_req;

    touch_virtual_keypad_mapper i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("TB_ERROR");
        $finish;
    end

    // receiver: random backpressure, plus one long hold-off on request
    initial
    begin
        m_tready <= 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 0;
                m_tready <= 0;
                repeat (400) @(posedge clk);
            end
            m_tready <= calm || $urandom_range(99) >= 34;
        end
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_beat(m_tdata);

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_wen <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    task automatic setup(bit en, bit hd, logic [15:0] w, logic [15:0] h, logic [15:0] us);
        write_reg(REG_ENABLE, 16'(en));
        write_reg(REG_HIDE, 16'(hd));
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_SCALE, us);
        cfg_wen <= 0;
        @(posedge clk);
    endtask

    task automatic send_event(logic [2:0] op, logic [31:0] id, logic [15:0] x, logic [15:0] y);
        if (!calm && $urandom_range(99) < 34)
        begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tuser <= op;
        s_tdata <= {y, x, id};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_event(op, id, x, y);
    endtask

    task automatic settle();
        s_tvalid <= 0;
        while (sb.expected_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    // fractional position of a pixel coordinate given in Q16
    function automatic logic [15:0] frac_of(longint pq16, longint dim);
        longint v;
        v = pq16 / dim;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v[15:0];
    endfunction

    task automatic aim_key(int k, longint jit, output logic [15:0] x, output logic [15:0] y);
        longint s, wq, hq, cx, cy;
        s = sb.scale();
        wq = sb.width * 65536;
        hq = sb.height * 65536;
        case (k)
            0: begin cx = 90 * s; cy = hq - 140 * s; end
            1: begin cx = 90 * s; cy = hq - 40 * s; end
            2: begin cx = 40 * s; cy = hq - 90 * s; end
            3: begin cx = 140 * s; cy = hq - 90 * s; end
            4: begin cx = 125 * s; cy = hq - 125 * s; end
            5: begin cx = wq - 55 * s; cy = hq - 105 * s; end
            6: begin cx = wq - 125 * s; cy = hq - 55 * s; end
            7: begin cx = (sb.width * 131072) / 5; cy = hq - 30 * s; end
            8: begin cx = (sb.width * 196608) / 5; cy = hq - 30 * s; end
            9: begin cx = wq - 40 * s; cy = 35 * s; end
            default: begin cx = 90 * s; cy = hq - 90 * s; end
        endcase
        if (jit > 0)
        begin
            cx += longint'($urandom_range(0, 2 * jit)) - jit;
            cy += longint'($urandom_range(0, 2 * jit)) - jit;
        end
        x = frac_of(cx, sb.width);
        y = frac_of(cy, sb.height);
    endtask

    task automatic random_events(int n);
        logic [2:0]  op;
        logic [31:0] id;
        logic [15:0] x, y;
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 32) op = OP_DOWN;
            else if (r < 62) op = OP_MOVE;
            else if (r < 86) op = OP_UP;
            else if (r < 92) op = OP_PAD;
            else if (r < 96) op = OP_CLEAR;
            else op = 3'($urandom_range(5, 7));
            r = $urandom_range(99);
            if (r < 80) id = $urandom_range(0, 13);
            else if (r < 85) id = 32'hFFFF_FFFF;
            else id = $urandom;
            if ($urandom_range(99) < 60)
                aim_key($urandom_range(0, 10), 40 * sb.scale(), x, y);
            else
            begin
                x = 16'($urandom);
                y = 16'($urandom);
            end
            send_event(op, id, x, y);
        end
    endtask

    initial
    begin
        logic [15:0] x, y;
        sb = new();
        calm = 0;
        hold_req = 0;
        rst_n <= 0;
        cfg_wen <= 0;
        cfg_index <= '0;
        cfg_data <= '0;
        s_tvalid <= 0;
        s_tdata <= '0;
        s_tuser <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        repeat (4) @(posedge clk);

        // mapping off after reset: slots untouched, lines high
        random_events(20);
        settle();

        setup(1, 1, 640, 480, 4096);
        for (int k = 0; k < 11; k++)
        begin
            aim_key(k, 0, x, y);
            send_event(OP_DOWN, k, x, y);
        end
        send_event(OP_DOWN, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);   // table full
        send_event(OP_PAD, 0, 0, 0);
        send_event(OP_RSV5, 0, 0, 0);
        send_event(OP_RSV7, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        send_event(OP_UP, 32'h1234_5678, 0, 0);                    // unknown finger
        send_event(OP_CLEAR, 0, 0, 0);
        send_event(OP_MOVE, 0, 0, 0);
        send_event(OP_UP, 5, 0, 0);
        send_event(OP_DOWN, 0, 16'hFFFF, 16'h0000);               // duplicate id
        send_event(OP_UP, 0, 0, 0);
        send_event(OP_MOVE, 0, 0, 16'hFFFF);
        settle();

        random_events(120);
        calm = 1;
        hold_req = 1;
        random_events(100);
        calm = 0;
        settle();

        setup(1, 0, 640, 480, 4096);
        random_events(90);
        settle();

        setup(1, 1, 1, 1, 0);
        random_events(60);
        settle();

        setup(1, 0, 4095, 4095, 16'hFFFF);
        random_events(60);
        settle();

        setup(1, 1'($urandom_range(0, 1)), 16'($urandom_range(200, 4095)),
              16'($urandom_range(200, 4095)), 16'($urandom_range(0, 16'hFFFF)));
        random_events(70);
        settle();

        setup(0, 1, 800, 600, 8192);
        random_events(20);
        settle();

        setup(1, 1, 1280, 720, 3000);
        random_events(70);
        settle();

        if (sb.mismatches == 0 && sb.expected_beats.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
